FILE: hdl/mms_pkg.sv
// shared types and constants of the min/max stack
package mms_pkg;

	localparam int DEPTH = 1024;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		REQ_PUSH = 3'd0,
		REQ_POP  = 3'd1,
		REQ_TOP  = 3'd2,
		REQ_MAX  = 3'd3,
		REQ_MIN  = 3'd4
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] read_value;
	} rsp_t;

	// one stack entry with the extremes from the bottom up to it
	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] max;
		logic signed [31:0] min;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} shift_t;

endpackage

FILE: hdl/mms_cell.sv
// one stack slot: takes the entry above on push, the entry below on pop
module mms_cell
	import mms_pkg::*;
(
	input  logic   clk,
	input  shift_t shift,
	input  entry_t from_above,
	input  entry_t from_below,
	output entry_t entry
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift.push) begin
			entry_q <= from_above;
		end else if (shift.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

FILE: hdl/mms_row.sv
// row of DEPTH cells; the top of the stack always sits in cell 0
module mms_row
	import mms_pkg::*;
(
	input  logic   clk,
	input  shift_t shift,
	input  entry_t new_entry,
	output entry_t top_entry
);

	entry_t entries [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t above;
		entry_t below;

		if (i == 0) begin : g_first
			assign above = new_entry;
		end else begin : g_mid_above
			assign above = entries[i - 1];
		end

		// nothing lives beyond the last cell
		if (i == DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_mid_below
			assign below = entries[i + 1];
		end

		mms_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.from_above (above),
			.from_below (below),
			.entry      (entries[i])
		);
	end

	assign top_entry = entries[0];

endmodule

FILE: hdl/min_max_stack.sv
// min/max stack: the response to an accepted request is registered and held until taken;
// throughput one request per cycle while responses are taken; a request is
// held off only while an earlier response waits and rsp_ready is low
// the whole cell row shifts at once, so push and pop cost no more than other requests
// reset clears the fill count and the response valid; cell contents stay undefined
module min_max_stack
	import mms_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	entry_t           top_entry;
	entry_t           new_entry;
	shift_t           shift;
	logic             accept;
	logic             full;
	logic             empty;
	rsp_t             rsp_next;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	assign shift.push = accept && (req.req_type == REQ_PUSH) && !full;
	assign shift.pop  = accept && (req.req_type == REQ_POP) && !empty;

	always_comb begin
		new_entry.value = req.push_value;
		new_entry.max   = req.push_value;
		new_entry.min   = req.push_value;
		if (!empty) begin
			if (top_entry.max > req.push_value) begin
				new_entry.max = top_entry.max;
			end
			if (top_entry.min < req.push_value) begin
				new_entry.min = top_entry.min;
			end
		end
	end

	always_comb begin
		rsp_next.status     = ST_OK;
		rsp_next.read_value = '0;
		unique case (req.req_type)
			REQ_PUSH: begin
				if (full) begin
					rsp_next.status = ST_OVERFLOW;
				end
			end
			REQ_POP: begin
				if (empty) begin
					rsp_next.status = ST_UNDERFLOW;
				end
			end
			REQ_TOP, REQ_MAX, REQ_MIN: begin
				if (empty) begin
					rsp_next.status = ST_EMPTY;
				end else if (req.req_type == REQ_TOP) begin
					rsp_next.read_value = top_entry.value;
				end else if (req.req_type == REQ_MAX) begin
					rsp_next.read_value = top_entry.max;
				end else begin
					rsp_next.read_value = top_entry.min;
				end
			end
			// unused codes answer ok with zero data
			default: begin
			end
		endcase
	end

	mms_row u_row (
		.clk       (clk),
		.shift     (shift),
		.new_entry (new_entry),
		.top_entry (top_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (shift.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (shift.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count beyond capacity");

	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		shift.push |=> top_entry.value == $past(req.push_value))
		else $error("pushed value not on top");

	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (top_entry.max >= top_entry.value) && (top_entry.min <= top_entry.value))
		else $error("top extremes do not bound top value");

	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && empty && (req.req_type == REQ_TOP || req.req_type == REQ_MAX
			|| req.req_type == REQ_MIN) |=> rsp_valid && rsp.status == ST_EMPTY)
		else $error("read of empty stack not reported");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("fill count moved without a transaction");

endmodule
